### rtl/fsc_pkg.sv
// ----------------------------------------------------------------------------
// fsc_pkg
// shared widths, action codes and the rule table of the fuzzy speed controller
// ----------------------------------------------------------------------------
package fsc_pkg;

  localparam int DATA_W        = 16;
  localparam int SCORE_W       = 13;
  localparam int ACTION_W      = 3;
  localparam int NUM_SETS      = 5;
  localparam int FRAC_BITS_DEF = 8;

  // ends of the raw input range, used where a set runs off either end
  localparam int RAW_LO = -32768;
  localparam int RAW_HI = 32767;

  typedef enum logic [ACTION_W-1:0] {
    ACT_BRAKE_HARD = 3'd0,
    ACT_SLOW_DOWN  = 3'd1,
    ACT_MAINTAIN   = 3'd2,
    ACT_SPEED_UP   = 3'd3,
    ACT_FLOOR_IT   = 3'd4
  } action_t;

  // rows: distance set, columns: delta set
  localparam action_t RULES [NUM_SETS][NUM_SETS] = '{
    '{ACT_BRAKE_HARD, ACT_BRAKE_HARD, ACT_SLOW_DOWN, ACT_SLOW_DOWN, ACT_MAINTAIN},
    '{ACT_BRAKE_HARD, ACT_SLOW_DOWN,  ACT_SLOW_DOWN, ACT_MAINTAIN,  ACT_SPEED_UP},
    '{ACT_SLOW_DOWN,  ACT_SLOW_DOWN,  ACT_MAINTAIN,  ACT_SPEED_UP,  ACT_SPEED_UP},
    '{ACT_SLOW_DOWN,  ACT_MAINTAIN,   ACT_SPEED_UP,  ACT_SPEED_UP,  ACT_FLOOR_IT},
    '{ACT_MAINTAIN,   ACT_SPEED_UP,   ACT_SPEED_UP,  ACT_FLOOR_IT,  ACT_FLOOR_IT}
  };

endpackage

### rtl/fuzzy_speed_controller.sv
// ----------------------------------------------------------------------------
// fuzzy_speed_controller
// fuzzy speed advice for a following car from gap and gap change
// ----------------------------------------------------------------------------
// usage
//   request channel: drive distance and distance_delta (signed fixed point,
//   FRAC_BITS fraction bits) and raise start; the request is taken at any
//   rising edge where start is high and busy is low
//   busy is high only while rst is held, so a request fits in every cycle
//   result channel: done is high for exactly one cycle, and action plus the
//   five score ports are valid in that cycle; there is no backpressure, the
//   receiver must take the result when done is high
// timing
//   one request per cycle sustained; done follows the request through the
//   input register, the grade register (trapezoid grading with the two
//   reciprocal multipliers), the score register (min and rule sums) and the
//   result register (argmax)
// reset
//   synchronous rst clears every stage valid, so requests in flight are
//   dropped and no done is given for them
// ----------------------------------------------------------------------------
module fuzzy_speed_controller import fsc_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [DATA_W-1:0] distance,
  input  logic signed [DATA_W-1:0] distance_delta,
  output logic                     done,
  output logic [ACTION_W-1:0]      action,
  output logic [SCORE_W-1:0]       score_brake_hard,
  output logic [SCORE_W-1:0]       score_slow_down,
  output logic [SCORE_W-1:0]       score_maintain,
  output logic [SCORE_W-1:0]       score_speed_up,
  output logic [SCORE_W-1:0]       score_floor_it
);

  localparam int GW    = FRAC_BITS + 1;
  localparam int SUM_W = FRAC_BITS + 4;

  // request handshake
  logic accept;

  // stage valids
  logic in_valid;
  logic grade_valid;
  logic score_valid;

  // stage registers and their next values
  logic signed [DATA_W-1:0] held_distance;
  logic signed [DATA_W-1:0] held_delta;
  logic [GW-1:0]            dist_grades        [NUM_SETS];
  logic [GW-1:0]            delta_grades       [NUM_SETS];
  logic [GW-1:0]            dist_grades_next   [NUM_SETS];
  logic [GW-1:0]            delta_grades_next  [NUM_SETS];
  logic [SUM_W-1:0]         scores             [NUM_SETS];
  logic [SUM_W-1:0]         scores_next        [NUM_SETS];
  action_t                  action_next;

  // never stalls, only held off while in reset
  assign busy   = rst;
  assign accept = start && !busy;

  // stage 1: grade both inputs against their sets
  fsc_fuzzify #(
    .FRAC_BITS (FRAC_BITS)
  ) u_fuzzify (
    .distance       (held_distance),
    .distance_delta (held_delta),
    .dist_grade     (dist_grades_next),
    .delta_grade    (delta_grades_next)
  );

  // stage 2: rule strengths summed per action
  fsc_infer #(
    .FRAC_BITS (FRAC_BITS)
  ) u_infer (
    .dist_grade  (dist_grades),
    .delta_grade (delta_grades),
    .score       (scores_next)
  );

  // stage 3: strictly largest full-width sum, first one wins ties,
  // all zero falls back to brake hard
  always_comb begin
    logic [SUM_W-1:0] best;
    best        = '0;
    action_next = ACT_BRAKE_HARD;
    for (int k = 0; k < NUM_SETS; k++) begin
      if (scores[k] > best) begin
        best        = scores[k];
        action_next = action_t'(k);
      end
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid    <= 1'b0;
      grade_valid <= 1'b0;
      score_valid <= 1'b0;
      done        <= 1'b0;
    end else begin
      in_valid    <= accept;
      grade_valid <= in_valid;
      score_valid <= grade_valid;
      done        <= score_valid;
    end
  end

  // payload, loaded only when the stage below holds a live request
  always_ff @(posedge clk) begin
    if (accept) begin
      held_distance <= distance;
      held_delta    <= distance_delta;
    end
    if (in_valid) begin
      dist_grades  <= dist_grades_next;
      delta_grades <= delta_grades_next;
    end
    if (grade_valid) begin
      scores <= scores_next;
    end
    if (score_valid) begin
      action           <= action_next;
      // sums wider than the port wrap to the low bits
      score_brake_hard <= SCORE_W'(scores[ACT_BRAKE_HARD]);
      score_slow_down  <= SCORE_W'(scores[ACT_SLOW_DOWN]);
      score_maintain   <= SCORE_W'(scores[ACT_MAINTAIN]);
      score_speed_up   <= SCORE_W'(scores[ACT_SPEED_UP]);
      score_floor_it   <= SCORE_W'(scores[ACT_FLOOR_IT]);
    end
  end

  // every request gives exactly one done
  assert property (@(posedge clk) disable iff (rst) accept |-> ##4 done)
    else $error("request without result");

  assert property (@(posedge clk) disable iff (rst) done |-> $past(accept, 4))
    else $error("result without request");

  // no cell fired: fall back to brake hard
  assert property (@(posedge clk) disable iff (rst)
    score_valid && scores[ACT_BRAKE_HARD] == '0 && scores[ACT_SLOW_DOWN] == '0 &&
    scores[ACT_MAINTAIN] == '0 && scores[ACT_SPEED_UP] == '0 &&
    scores[ACT_FLOOR_IT] == '0 |=> action == ACT_BRAKE_HARD)
    else $error("all-zero scores did not pick brake hard");

endmodule

### rtl/fsc_fuzzify.sv
// ----------------------------------------------------------------------------
// fsc_fuzzify
// grades distance and delta against their five trapezoid sets
// ----------------------------------------------------------------------------
module fsc_fuzzify import fsc_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic signed [DATA_W-1:0] distance,
  input  logic signed [DATA_W-1:0] distance_delta,
  output logic [FRAC_BITS:0]       dist_grade  [NUM_SETS],
  output logic [FRAC_BITS:0]       delta_grade [NUM_SETS]
);

  localparam int GW   = FRAC_BITS + 1;
  localparam int XW   = DATA_W + 2;
  localparam int HALF = 1 << (FRAC_BITS - 1);
  localparam int ONE  = 1 << FRAC_BITS;

  localparam logic [GW-1:0] ONE_G = {1'b1, {FRAC_BITS{1'b0}}};

  // long ramps that run to the range ends: q = floor(n * ONE / K) as (n * M) >> 2*N_W
  localparam int     N_W   = DATA_W - 1;
  localparam int     SHIFT = 2 * N_W;
  localparam int     MW    = FRAC_BITS + N_W + 2;
  localparam int     PW    = N_W + MW;
  localparam longint K_SF  = longint'(RAW_HI) + 1 - ONE;
  localparam longint K_GF  = longint'(RAW_HI) - ONE;
  localparam longint M_SF  = ((longint'(1) <<< (SHIFT + FRAC_BITS)) + K_SF - 1) / K_SF;
  localparam longint M_GF  = ((longint'(1) <<< (SHIFT + FRAC_BITS)) + K_GF - 1) / K_GF;

  // ramp of width HALF << k
  function automatic logic [GW-1:0] ramp(input logic signed [XW-1:0] diff, input int k);
    logic [XW:0] dbl;
    dbl = {diff, 1'b0};
    return GW'(dbl >> k);
  endfunction

  function automatic logic [GW-1:0] trap(input logic signed [XW-1:0] x,
                                         input int a, input int b, input int c, input int d,
                                         input logic [GW-1:0] rise, input logic [GW-1:0] fall);
    logic [GW-1:0] g;
    if (x < a || x > d) begin
      g = '0;
    end else if (x < b) begin
      g = rise;
    end else if (x <= c) begin
      g = ONE_G;
    end else begin
      g = fall;
    end
    return g;
  endfunction

  logic signed [XW-1:0] dx;
  logic signed [XW-1:0] vx;
  logic [N_W-1:0]       n_sf;
  logic [N_W-1:0]       n_gf;
  logic [PW-1:0]        p_sf;
  logic [PW-1:0]        p_gf;
  logic [GW-1:0]        rec_sf;
  logic [GW-1:0]        rec_gf;

  assign dx = XW'(distance);
  assign vx = XW'(distance_delta);

  assign n_sf   = N_W'(vx - RAW_LO);
  assign n_gf   = N_W'(RAW_HI - vx);
  assign p_sf   = PW'(n_sf) * PW'(M_SF);
  assign p_gf   = PW'(n_gf) * PW'(M_GF);
  assign rec_sf = p_sf[SHIFT +: GW];
  assign rec_gf = p_gf[SHIFT +: GW];

  always_comb begin
    dist_grade[0] = trap(dx, RAW_LO, RAW_LO, HALF, ONE,
                         '0, ramp(XW'(ONE - dx), 0));
    dist_grade[1] = trap(dx, HALF, ONE, ONE, 2 * ONE,
                         ramp(XW'(dx - HALF), 0), ramp(XW'(2 * ONE - dx), 1));
    dist_grade[2] = trap(dx, ONE, 2 * ONE, 2 * ONE, 3 * ONE,
                         ramp(XW'(dx - ONE), 1), ramp(XW'(3 * ONE - dx), 1));
    dist_grade[3] = trap(dx, 2 * ONE, 3 * ONE, 3 * ONE, 4 * ONE,
                         ramp(XW'(dx - 2 * ONE), 1), ramp(XW'(4 * ONE - dx), 1));
    dist_grade[4] = trap(dx, 3 * ONE, 5 * ONE, RAW_HI, RAW_HI,
                         ramp(XW'(dx - 3 * ONE), 2), '0);

    delta_grade[0] = trap(vx, RAW_LO, -ONE, -ONE, -HALF,
                          rec_sf, ramp(XW'(-HALF - vx), 0));
    delta_grade[1] = trap(vx, -ONE, -HALF, -HALF, 0,
                          ramp(XW'(vx + ONE), 0), ramp(XW'(0 - vx), 0));
    delta_grade[2] = trap(vx, -HALF, 0, 0, HALF,
                          ramp(XW'(vx + HALF), 0), ramp(XW'(HALF - vx), 0));
    delta_grade[3] = trap(vx, 0, HALF, HALF, ONE,
                          ramp(XW'(vx - 0), 0), ramp(XW'(ONE - vx), 0));
    delta_grade[4] = trap(vx, HALF, ONE, ONE, RAW_HI,
                          ramp(XW'(vx - HALF), 0), rec_gf);
  end

endmodule

### rtl/fsc_infer.sv
// ----------------------------------------------------------------------------
// fsc_infer
// min of each grade pair, summed per action through the rule table
// ----------------------------------------------------------------------------
module fsc_infer import fsc_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic [FRAC_BITS:0]   dist_grade  [NUM_SETS],
  input  logic [FRAC_BITS:0]   delta_grade [NUM_SETS],
  output logic [FRAC_BITS+3:0] score       [NUM_SETS]
);

  localparam int GW    = FRAC_BITS + 1;
  localparam int SUM_W = FRAC_BITS + 4;

  always_comb begin
    logic [GW-1:0] s;
    s = '0;
    for (int a = 0; a < NUM_SETS; a++) begin
      score[a] = '0;
    end
    for (int i = 0; i < NUM_SETS; i++) begin
      for (int j = 0; j < NUM_SETS; j++) begin
        s = (dist_grade[i] < delta_grade[j]) ? dist_grade[i] : delta_grade[j];
        score[RULES[i][j]] = score[RULES[i][j]] + SUM_W'(s);
      end
    end
  end

endmodule
